/* design/sgcc_pkg.sv */
// Shared types, widths and constants for the social Gaussian cell cost block.
// Holds the exp lookup table, built at elaboration. No dependencies.
package sgcc_pkg;

  // exp table size (entry k holds exp(-8k/N) in Q16)
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int IdxW    = $clog2(EXP_TABLE_ENTRIES);
  localparam int IdxMulW = 20 + $clog2(EXP_TABLE_ENTRIES + 1);

  // field widths
  localparam int DW    = 16;  // offsets
  localparam int VW    = 14;  // velocities
  localparam int CW    = 8;   // costs
  localparam int S2W   = 28;  // squared speed
  localparam int RootW = 14;  // integer speed
  localparam int MagW  = 30;  // |dot|, |cross|
  localparam int QuoW  = 17;  // rotated offsets
  localparam int LX2W  = 34;  // squared rotated offsets
  localparam int SFW   = 19;  // front sigma
  localparam int SSW   = 15;  // side sigma
  localparam int SX2W  = 38;  // squared sigma
  localparam int TermW = 20;  // one exponent term, Q16, below 16.0
  localparam int QShift = 16;
  localparam int LoW   = TermW - QShift;
  localparam int FW    = 17;  // exp value, Q16
  localparam int ProdW = CW + FW;
  localparam int InTdataW = 72;

  // cost codes
  localparam logic [CW-1:0] COST_LETHAL  = 8'd254;
  localparam logic [CW-1:0] COST_GAUSS_MAX = 8'd253;
  localparam logic [CW-1:0] COST_UNKNOWN = 8'd255;

  // register clamps
  localparam int BaseMin  = 51;
  localparam int RatioMin = 13;
  localparam int FloorMin = 1;

  typedef enum logic [2:0] {
    REG_LAYER_EN  = 3'd0,
    REG_PEAK      = 3'd1,
    REG_BASE      = 3'd2,
    REG_RATIO     = 3'd3,
    REG_GAIN      = 3'd4,
    REG_CORE      = 3'd5,
    REG_FLOOR     = 3'd6,
    REG_THRESHOLD = 3'd7
  } cfg_reg_e;

  typedef logic [FW-1:0] exp_tab_t [EXP_TABLE_ENTRIES];

  localparam longint unsigned Q30One = 64'd1 << 30;

  // exp(-f), f and result in Q30, series up to the f^16 term
  function automatic longint unsigned exp_neg_q30(longint unsigned f);
    longint          sum;
    longint unsigned term;
    sum  = longint'(Q30One);
    term = Q30One;
    for (int unsigned i = 1; i <= 16; i++) begin
      term = ((term * f) >> 30) / 64'(i);
      if (i[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : unsigned'(sum);
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t        tab;
    longint unsigned e1;
    longint unsigned x;
    longint unsigned whole;
    longint unsigned p;
    e1 = exp_neg_q30(Q30One);
    for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
      x     = (64'(k) << 33) / EXP_TABLE_ENTRIES;
      whole = x >> 30;
      p     = exp_neg_q30(x & (Q30One - 64'd1));
      for (longint unsigned n = 0; n < whole; n++) begin
        p = (p * e1 + (Q30One >> 1)) >> 30;
      end
      tab[k] = FW'((p + (64'd1 << 13)) >> 14);
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage

/* design/sgcc_ratio.sv */
// Pipelined restoring divider: floor(num * 2^16 / den), saturating flag when >= 2^20.
// One quotient bit per stage, 21 register stages. Uses sgcc_pkg.
module sgcc_ratio (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [sgcc_pkg::LX2W-1:0]  num_i,
  input  logic [sgcc_pkg::SX2W-1:0]  den_i,
  output logic [sgcc_pkg::TermW-1:0] quo_o,
  output logic                       big_o
);
  import sgcc_pkg::*;

  typedef struct packed {
    logic [SX2W-1:0]  rem;
    logic [SX2W-1:0]  den;
    logic [LoW-1:0]   nlo;
    logic [TermW-1:0] quo;
    logic             big;
  } rs_t;

  rs_t st_q [TermW+1];

  // entry: high part of the dividend, overflow check
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem <= SX2W'(num_i[LX2W-1:LoW]);
      st_q[0].den <= den_i;
      st_q[0].nlo <= num_i[LoW-1:0];
      st_q[0].quo <= '0;
      st_q[0].big <= SX2W'(num_i[LX2W-1:LoW]) >= den_i;
    end
  end

  for (genvar j = 1; j <= TermW; j++) begin : g_step
    localparam int Bit = TermW - j;
    logic          nbit;
    logic [SX2W:0] trial;
    logic [SX2W:0] diff;
    rs_t           st_d;

    if (Bit >= QShift) begin : g_lo
      assign nbit = st_q[j-1].nlo[Bit-QShift];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign trial = {st_q[j-1].rem, nbit};
    assign diff  = trial - {1'b0, st_q[j-1].den};

    always_comb begin
      st_d = st_q[j-1];
      if (trial >= {1'b0, st_q[j-1].den}) begin
        st_d.rem      = diff[SX2W-1:0];
        st_d.quo[Bit] = 1'b1;
      end else begin
        st_d.rem = trial[SX2W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j] <= st_d;
      end
    end
  end

  assign quo_o = st_q[TermW].quo;
  assign big_o = st_q[TermW].big;

endmodule

/* design/social_gaussian_cell_cost.sv */
// Social Gaussian cell cost: top level, config registers and main pipeline.
// Depends on sgcc_pkg and sgcc_ratio (two instances for the exponent terms).
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: offset_x, offset_y, vel_x,
//           |     |                        |        vel_y, prior_cost
//  m_axis   | out | m_axis_tvalid/tready   | tdata: cell_cost, tuser: write_cell
//  cfg      | in  | cfg_valid/cfg_ready    | cfg_index_i, cfg_data_i
//
// One request per clock sustained while m_axis is not stalled; pipeline of 2 product/sum stages,
// 14 square-root bit stages, 17 division bit stages for the rotated offsets,
// 3 sigma stages, 21 stages in each exponent divider, 3 table/scale stages and the
// output register. The whole pipeline advances whenever the output register
// is empty or taken, so a stall freezes every stage in place. Reset clears
// valid bits and loads the default register values. cfg is always ready.
module social_gaussian_cell_cost (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [15:0] offset_x, [31:16] offset_y, [45:32] vel_x, [59:46] vel_y,
  // [67:60] prior_cost, [71:68] zero
  input  logic [sgcc_pkg::InTdataW-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] cell_cost
  output logic [sgcc_pkg::CW-1:0]         m_axis_tdata_o,
  // [0] write_cell
  output logic                            m_axis_tuser_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [2:0]                      cfg_index_i,
  input  logic [12:0]                     cfg_data_i
);
  import sgcc_pkg::*;

  localparam int PEnd = RootW + QuoW;

  // ---------------- configuration ----------------
  logic        en_q;
  logic [7:0]  peak_q;
  logic [12:0] base_q;
  logic [9:0]  ratio_q;
  logic [9:0]  gain_q;
  logic [11:0] core_q;
  logic [7:0]  floor_q;
  logic [12:0] thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b1;
      peak_q  <= 8'd220;
      base_q  <= 13'd461;
      ratio_q <= 10'd154;
      gain_q  <= 10'd410;
      core_q  <= 12'd307;
      floor_q <= 8'd15;
      thr_q   <= 13'd51;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LAYER_EN:  en_q    <= cfg_data_i[0];
        REG_PEAK:      peak_q  <= cfg_data_i[7:0];
        REG_BASE:      base_q  <= cfg_data_i;
        REG_RATIO:     ratio_q <= cfg_data_i[9:0];
        REG_GAIN:      gain_q  <= cfg_data_i[9:0];
        REG_CORE:      core_q  <= cfg_data_i[11:0];
        REG_FLOOR:     floor_q <= cfg_data_i[7:0];
        REG_THRESHOLD: thr_q   <= cfg_data_i;
      endcase
    end
  end

  // clamped register values
  logic [12:0] base_eff;
  logic [9:0]  ratio_eff;
  logic [7:0]  peak_eff;
  logic [7:0]  floor_eff;
  logic [23:0] core2;
  logic [25:0] thr2;

  assign base_eff  = (base_q < 13'(BaseMin)) ? 13'(BaseMin) : base_q;
  assign ratio_eff = (ratio_q < 10'(RatioMin)) ? 10'(RatioMin) : ratio_q;
  assign peak_eff  = (peak_q > COST_GAUSS_MAX) ? COST_GAUSS_MAX : peak_q;
  assign floor_eff = (floor_q < 8'(FloorMin)) ? 8'(FloorMin) : floor_q;
  assign core2     = core_q * core_q;
  assign thr2      = thr_q * thr_q;

  // global advance: output slot free or being taken
  logic adv;
  logic acc;
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign acc             = s_axis_tvalid_i && adv;

  // ---------------- stage A: products ----------------
  typedef struct packed {
    logic               valid;
    logic [CW-1:0]      prior;
    logic [30:0]        dxx;
    logic [30:0]        dyy;
    logic [26:0]        vxx;
    logic [26:0]        vyy;
    logic signed [29:0] pxd;
    logic signed [29:0] pyd;
    logic signed [29:0] pxe;
    logic signed [29:0] pye;
    logic [DW-1:0]      adx;
    logic [DW-1:0]      ady;
  } a_t;

  logic signed [DW-1:0] in_dx, in_dy;
  logic signed [VW-1:0] in_vx, in_vy;
  logic signed [31:0]   sq_dx, sq_dy;
  logic signed [27:0]   sq_vx, sq_vy;
  logic signed [29:0]   m_xd, m_yd, m_xe, m_ye;
  a_t                   a_q;

  assign in_dx = s_axis_tdata_i[15:0];
  assign in_dy = s_axis_tdata_i[31:16];
  assign in_vx = s_axis_tdata_i[45:32];
  assign in_vy = s_axis_tdata_i[59:46];
  assign sq_dx = in_dx * in_dx;
  assign sq_dy = in_dy * in_dy;
  assign sq_vx = in_vx * in_vx;
  assign sq_vy = in_vy * in_vy;
  assign m_xd  = in_vx * in_dx;
  assign m_yd  = in_vy * in_dy;
  assign m_xe  = in_vx * in_dy;
  assign m_ye  = in_vy * in_dx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (adv) begin
      a_q.valid <= acc;
      a_q.prior <= s_axis_tdata_i[67:60];
      a_q.dxx   <= sq_dx[30:0];
      a_q.dyy   <= sq_dy[30:0];
      a_q.vxx   <= sq_vx[26:0];
      a_q.vyy   <= sq_vy[26:0];
      a_q.pxd   <= m_xd;
      a_q.pyd   <= m_yd;
      a_q.pxe   <= m_xe;
      a_q.pye   <= m_ye;
      a_q.adx   <= in_dx[DW-1] ? DW'(-in_dx) : in_dx;
      a_q.ady   <= in_dy[DW-1] ? DW'(-in_dy) : in_dy;
    end
  end

  // ---------------- stage B: sums and tests, then sqrt and divide ----------------
  typedef struct packed {
    logic             valid;
    logic [CW-1:0]    prior;
    logic             lethal;
    logic             moving;
    logic [S2W-1:0]   s2;
    logic [RootW-1:0] root;
    logic [MagW-1:0]  dot_mag;
    logic             dot_neg;
    logic [MagW-1:0]  crs_mag;
    logic [DW-1:0]    adx;
    logic [DW-1:0]    ady;
    logic [QuoW-1:0]  qx;
    logic [QuoW-1:0]  qy;
  } pipe_t;

  logic [31:0]        b_d2;
  logic [S2W-1:0]     b_s2;
  logic signed [30:0] b_dot, b_crs;
  pipe_t              pl_q [PEnd+1];

  assign b_d2  = {1'b0, a_q.dxx} + {1'b0, a_q.dyy};
  assign b_s2  = S2W'(a_q.vxx) + S2W'(a_q.vyy);
  assign b_dot = 31'(a_q.pxd) + 31'(a_q.pyd);
  assign b_crs = 31'(a_q.pxe) - 31'(a_q.pye);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q[0] <= '0;
    end else if (adv) begin
      pl_q[0].valid   <= a_q.valid;
      pl_q[0].prior   <= a_q.prior;
      pl_q[0].lethal  <= b_d2 <= 32'(core2);
      pl_q[0].moving  <= b_s2 >= S2W'(thr2);
      pl_q[0].s2      <= b_s2;
      pl_q[0].root    <= '0;
      pl_q[0].dot_mag <= b_dot[30] ? MagW'(-b_dot) : b_dot[MagW-1:0];
      pl_q[0].dot_neg <= b_dot[30];
      pl_q[0].crs_mag <= b_crs[30] ? MagW'(-b_crs) : b_crs[MagW-1:0];
      pl_q[0].adx     <= a_q.adx;
      pl_q[0].ady     <= a_q.ady;
      pl_q[0].qx      <= '0;
      pl_q[0].qy      <= '0;
    end
  end

  // integer square root of the squared speed, one bit per stage
  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    localparam int Bit = RootW - 1 - k;
    logic [RootW-1:0] cand;
    logic [S2W-1:0]   csq;
    pipe_t            pl_d;

    assign cand = pl_q[k].root | (RootW'(1) << Bit);
    assign csq  = cand * cand;

    always_comb begin
      pl_d = pl_q[k];
      if (csq <= pl_q[k].s2) pl_d.root = cand;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pl_q[k+1] <= '0;
      end else if (adv) begin
        pl_q[k+1] <= pl_d;
      end
    end
  end

  // |dot|/s and |cross|/s, one quotient bit per stage
  for (genvar k = RootW; k < PEnd; k++) begin : g_div
    localparam int Bit = PEnd - 1 - k;
    logic [QuoW-1:0]       cx, cy;
    logic [QuoW+RootW-1:0] px, py;
    pipe_t                 pl_d;

    assign cx = pl_q[k].qx | (QuoW'(1) << Bit);
    assign cy = pl_q[k].qy | (QuoW'(1) << Bit);
    assign px = cx * pl_q[k].root;
    assign py = cy * pl_q[k].root;

    always_comb begin
      pl_d = pl_q[k];
      if (px <= (QuoW+RootW)'(pl_q[k].dot_mag)) pl_d.qx = cx;
      if (py <= (QuoW+RootW)'(pl_q[k].crs_mag)) pl_d.qy = cy;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pl_q[k+1] <= '0;
      end else if (adv) begin
        pl_q[k+1] <= pl_d;
      end
    end
  end

  // ---------------- C1: local offsets squared, speed gain ----------------
  typedef struct packed {
    logic            valid;
    logic [CW-1:0]   prior;
    logic            lethal;
    logic            moving;
    logic            front;
    logic [LX2W-1:0] lx2;
    logic [LX2W-1:0] ly2;
    logic [23:0]     gs;
  } c1_t;

  logic            c1_rot;
  logic [QuoW-1:0] c1_lx, c1_ly;
  c1_t             c1_q;

  // no rotation when standing, or when moving at zero speed (threshold zero)
  assign c1_rot = pl_q[PEnd].moving && (pl_q[PEnd].root != '0);
  assign c1_lx  = c1_rot ? pl_q[PEnd].qx : QuoW'(pl_q[PEnd].adx);
  assign c1_ly  = c1_rot ? pl_q[PEnd].qy : QuoW'(pl_q[PEnd].ady);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
    end else if (adv) begin
      c1_q.valid  <= pl_q[PEnd].valid;
      c1_q.prior  <= pl_q[PEnd].prior;
      c1_q.lethal <= pl_q[PEnd].lethal;
      c1_q.moving <= pl_q[PEnd].moving;
      c1_q.front  <= !pl_q[PEnd].dot_neg;
      c1_q.lx2    <= c1_lx * c1_lx;
      c1_q.ly2    <= c1_ly * c1_ly;
      c1_q.gs     <= gain_q * pl_q[PEnd].root;
    end
  end

  // ---------------- C2: sigma selection ----------------
  typedef struct packed {
    logic            valid;
    logic [CW-1:0]   prior;
    logic            lethal;
    logic [LX2W-1:0] lx2;
    logic [LX2W-1:0] ly2;
    logic [SFW-1:0]  sx;
    logic [SSW-1:0]  ss;
  } c2_t;

  logic [37:0] c2_front;
  logic [22:0] c2_side;
  logic [SFW-1:0] c2_sf;
  logic [SSW-1:0] c2_ss;
  c2_t         c2_q;

  // front sigma grows with speed (gain Q2.8, speed in 1/1024 m/s)
  assign c2_front = base_eff * (25'(1 << 18) + 25'(c1_q.gs)) + 38'(1 << 17);
  assign c2_sf    = SFW'(c2_front >> 18);
  assign c2_side  = base_eff * ratio_eff + 23'd128;
  assign c2_ss    = SSW'(c2_side >> 8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q <= '0;
    end else if (adv) begin
      c2_q.valid  <= c1_q.valid;
      c2_q.prior  <= c1_q.prior;
      c2_q.lethal <= c1_q.lethal;
      c2_q.lx2    <= c1_q.lx2;
      c2_q.ly2    <= c1_q.ly2;
      c2_q.sx     <= (c1_q.moving && c1_q.front) ? c2_sf : SFW'(base_eff);
      c2_q.ss     <= c1_q.moving ? c2_ss : SSW'(base_eff);
    end
  end

  // ---------------- C3: squared sigmas ----------------
  typedef struct packed {
    logic            valid;
    logic [CW-1:0]   prior;
    logic            lethal;
    logic [LX2W-1:0] lx2;
    logic [LX2W-1:0] ly2;
    logic [SX2W-1:0] sx2;
    logic [SX2W-1:0] ss2;
  } c3_t;

  logic [2*SSW-1:0] c3_ss2;
  c3_t              c3_q;

  assign c3_ss2 = c2_q.ss * c2_q.ss;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
    end else if (adv) begin
      c3_q.valid  <= c2_q.valid;
      c3_q.prior  <= c2_q.prior;
      c3_q.lethal <= c2_q.lethal;
      c3_q.lx2    <= c2_q.lx2;
      c3_q.ly2    <= c2_q.ly2;
      c3_q.sx2    <= c2_q.sx * c2_q.sx;
      c3_q.ss2    <= SX2W'(c3_ss2);
    end
  end

  // ---------------- exponent terms ----------------
  typedef struct packed {
    logic          valid;
    logic [CW-1:0] prior;
    logic          lethal;
  } sd_t;

  sd_t              sd_q [TermW+1];
  logic [TermW-1:0] tx, ty;
  logic             bigx, bigy;

  sgcc_ratio u_ratio_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (c3_q.lx2),
    .den_i (c3_q.sx2),
    .quo_o (tx),
    .big_o (bigx)
  );

  sgcc_ratio u_ratio_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (c3_q.ly2),
    .den_i (c3_q.ss2),
    .quo_o (ty),
    .big_o (bigy)
  );

  for (genvar k = 0; k <= TermW; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sd_q[k] <= '0;
      end else if (adv) begin
        if (k == 0) sd_q[k] <= '{valid: c3_q.valid, prior: c3_q.prior, lethal: c3_q.lethal};
        else        sd_q[k] <= sd_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- E1: table index ----------------
  typedef struct packed {
    logic            valid;
    logic [CW-1:0]   prior;
    logic            lethal;
    logic            skip;
    logic [IdxW-1:0] idx;
  } e1_t;

  logic [TermW:0]     e1_q_sum;
  logic [IdxMulW-1:0] e1_scaled;
  e1_t                e1_q;

  assign e1_q_sum  = (TermW+1)'(tx) + (TermW+1)'(ty);
  assign e1_scaled = IdxMulW'(e1_q_sum[TermW-1:0]) * IdxMulW'(EXP_TABLE_ENTRIES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q <= '0;
    end else if (adv) begin
      e1_q.valid  <= sd_q[TermW].valid;
      e1_q.prior  <= sd_q[TermW].prior;
      e1_q.lethal <= sd_q[TermW].lethal;
      // exponent of 8 or more: no cost
      e1_q.skip   <= bigx || bigy || e1_q_sum[TermW];
      e1_q.idx    <= IdxW'(e1_scaled >> TermW);
    end
  end

  // ---------------- E2: table read ----------------
  typedef struct packed {
    logic          valid;
    logic [CW-1:0] prior;
    logic          lethal;
    logic          skip;
    logic [FW-1:0] f;
  } e2_t;

  e2_t e2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_q <= '0;
    end else if (adv) begin
      e2_q.valid  <= e1_q.valid;
      e2_q.prior  <= e1_q.prior;
      e2_q.lethal <= e1_q.lethal;
      e2_q.skip   <= e1_q.skip;
      e2_q.f      <= ExpTab[e1_q.idx];
    end
  end

  // ---------------- E3: amplitude ----------------
  typedef struct packed {
    logic             valid;
    logic [CW-1:0]    prior;
    logic             lethal;
    logic             skip;
    logic [ProdW-1:0] prod;
  } e3_t;

  e3_t e3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e3_q <= '0;
    end else if (adv) begin
      e3_q.valid  <= e2_q.valid;
      e3_q.prior  <= e2_q.prior;
      e3_q.lethal <= e2_q.lethal;
      e3_q.skip   <= e2_q.skip;
      e3_q.prod   <= peak_eff * e2_q.f;
    end
  end

  // ---------------- output: floor, clamp, merge ----------------
  typedef struct packed {
    logic          valid;
    logic          wr;
    logic [CW-1:0] cost;
  } out_t;

  logic          o_below;
  logic [8:0]    o_raw;
  logic [CW-1:0] o_gauss;
  logic [CW-1:0] o_new;
  logic          o_wr;
  out_t          out_q;

  assign o_below = e3_q.prod < {1'b0, floor_eff, 16'd0};
  assign o_raw   = e3_q.prod[ProdW-1:16];
  assign o_gauss = (o_raw > 9'(COST_GAUSS_MAX)) ? COST_GAUSS_MAX : o_raw[CW-1:0];
  assign o_new   = e3_q.lethal ? COST_LETHAL : o_gauss;
  assign o_wr    = en_q && (e3_q.lethal || (!e3_q.skip && !o_below));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (adv) begin
      out_q.valid <= e3_q.valid;
      out_q.wr    <= o_wr;
      // unknown prior is replaced, known prior keeps the larger cost
      out_q.cost  <= (o_wr && (e3_q.prior == COST_UNKNOWN || o_new > e3_q.prior)) ?
                     o_new : e3_q.prior;
    end
  end

  assign m_axis_tvalid_o = out_q.valid;
  assign m_axis_tdata_o  = out_q.cost;
  assign m_axis_tuser_o  = out_q.wr;

  // ---------------- checks ----------------
  logic [S2W-1:0] chk_root_sq;
  assign chk_root_sq = pl_q[RootW].root * pl_q[RootW].root;

  a_disabled_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !en_q |-> !m_axis_tuser_o)
    else $error("write flagged while layer disabled");

  a_written_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o != COST_UNKNOWN)
    else $error("unknown cost written");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pl_q[RootW].valid |-> chk_root_sq <= pl_q[RootW].s2)
    else $error("square root overshoots");

endmodule
